// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante, outside reset.
`define TGPID_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tgpid assertion failed");

// Check cons in the cycle after ante, outside reset.
`define TGPID_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tgpid assertion failed");

// Check cons in the cycle after ante, reset included.
`define TGPID_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("tgpid assertion failed");

`endif

// ===== rtl/core/tgpid_pkg.sv =====
`default_nettype none

package tgpid_pkg;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_GAIN_P       = 3'd0;
    localparam logic [2:0] REG_GAIN_I       = 3'd1;
    localparam logic [2:0] REG_GAIN_D       = 3'd2;
    localparam logic [2:0] REG_SETPOINT     = 3'd3;
    localparam logic [2:0] REG_INT_PERIOD   = 3'd4;
    localparam logic [2:0] REG_DER_PERIOD   = 3'd5;

    // Item kinds carried in tuser
    localparam logic FUNC_COMPUTE = 1'b0;
    localparam logic FUNC_CLEAR   = 1'b1;

    localparam logic [9:0]  MS_PER_S  = 10'd1000;

    // Integral sum limits, 48-bit signed
    localparam logic [47:0] SUM_MAX   = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] SUM_MIN   = 48'h8000_0000_0000;

    // Drive limits, 32-bit signed
    localparam logic [31:0] DRIVE_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] DRIVE_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [31:0] gain_p;
        logic [31:0] gain_i;
        logic [31:0] gain_d;
        logic [31:0] setpoint;
        logic [15:0] int_period;
        logic [15:0] der_period;
    } t_cfg;

    // Operands handed from the state stage to the multiply stage
    typedef struct packed {
        logic        valid;
        logic [32:0] err;
        logic [47:0] sum;
        logic [34:0] d2;
        logic        iused;
        logic        dused;
    } t_work;

    // Period in seconds to milliseconds
    function automatic logic [25:0] period_ms(input logic [15:0] period_s);
        period_ms = {10'b0, period_s} * {16'b0, MS_PER_S};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tgpid_regs.sv =====
`default_nettype none

module tgpid_regs (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               psel,
    input  wire               penable,
    input  wire               pwrite,
    input  wire  [4:0]        paddr,
    input  wire  [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output tgpid_pkg::t_cfg   o_cfg
);

    logic [31:0] r_gain_p;
    logic [31:0] r_gain_i;
    logic [31:0] r_gain_d;
    logic [31:0] r_setpoint;
    logic [15:0] r_int_period;
    logic [15:0] r_der_period;
    logic        w_wr;
    logic [2:0]  w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[4:2];

    // Write on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p     <= '0;
            r_gain_i     <= '0;
            r_gain_d     <= '0;
            r_setpoint   <= '0;
            r_int_period <= 16'd1;
            r_der_period <= 16'd1;
        end else if (w_wr) begin
            case (w_idx)
                tgpid_pkg::REG_GAIN_P:     r_gain_p     <= pwdata;
                tgpid_pkg::REG_GAIN_I:     r_gain_i     <= pwdata;
                tgpid_pkg::REG_GAIN_D:     r_gain_d     <= pwdata;
                tgpid_pkg::REG_SETPOINT:   r_setpoint   <= pwdata;
                tgpid_pkg::REG_INT_PERIOD: r_int_period <= pwdata[15:0];
                tgpid_pkg::REG_DER_PERIOD: r_der_period <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (w_idx)
            tgpid_pkg::REG_GAIN_P:     prdata = r_gain_p;
            tgpid_pkg::REG_GAIN_I:     prdata = r_gain_i;
            tgpid_pkg::REG_GAIN_D:     prdata = r_gain_d;
            tgpid_pkg::REG_SETPOINT:   prdata = r_setpoint;
            tgpid_pkg::REG_INT_PERIOD: prdata = {16'b0, r_int_period};
            tgpid_pkg::REG_DER_PERIOD: prdata = {16'b0, r_der_period};
            default:                   prdata = '0;
        endcase
    end

    assign o_cfg = '{gain_p:     r_gain_p,
                     gain_i:     r_gain_i,
                     gain_d:     r_gain_d,
                     setpoint:   r_setpoint,
                     int_period: r_int_period,
                     der_period: r_der_period};

endmodule

`default_nettype wire

// ===== rtl/core/tgpid_state.sv =====
`default_nettype none

module tgpid_state (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire tgpid_pkg::t_cfg i_cfg,
    input  wire               i_tvalid,
    output logic              o_tready,
    input  wire  [63:0]       i_tdata,   // [31:0] measured, [63:32] now_ms
    input  wire  [0:0]        i_tuser,   // [0] func
    input  wire               i_ready,
    output tgpid_pkg::t_work  o_work
);

    // Input register
    logic        r_a_valid;
    logic        r_a_func;
    logic [31:0] r_a_meas;
    logic [31:0] r_a_now;

    // Operand register
    logic        r_b_valid;
    logic [32:0] r_b_err;
    logic [47:0] r_b_sum;
    logic [34:0] r_b_d2;
    logic        r_b_iused;
    logic        r_b_dused;

    // Controller state
    logic [47:0] r_isum;
    logic [31:0] r_itime;
    logic [31:0] r_dtime;
    logic [31:0] r_prev;
    logic [31:0] r_pprev;
    logic [1:0]  r_hist;

    logic        w_ready_a;
    logic        w_ready_b;
    logic        w_fire_ab;
    logic        w_compute;
    logic [32:0] w_err;
    logic [48:0] w_sum_raw;
    logic [47:0] w_sum_sat;
    logic [31:0] w_i_elapsed;
    logic [31:0] w_d_elapsed;
    logic        w_i_gate;
    logic        w_d_gate;
    logic        w_hist_full;
    logic [34:0] w_d2;

    // Handshake: each stage takes an item when empty or draining
    assign w_ready_b = !r_b_valid || i_ready;
    assign w_ready_a = !r_a_valid || w_ready_b;
    assign w_fire_ab = r_a_valid && w_ready_b;
    assign o_tready  = w_ready_a;
    assign w_compute = (r_a_func == tgpid_pkg::FUNC_COMPUTE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_ready_a) begin
            r_a_valid <= i_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tvalid && w_ready_a) begin
            r_a_func <= i_tuser[0];
            r_a_meas <= i_tdata[31:0];
            r_a_now  <= i_tdata[63:32];
        end
    end

    // Error, exact in 33 bits
    assign w_err = {i_cfg.setpoint[31], i_cfg.setpoint} - {r_a_meas[31], r_a_meas};

    // Saturating integral sum
    assign w_sum_raw = {r_isum[47], r_isum} + {{16{w_err[32]}}, w_err};
    always_comb begin
        if (w_sum_raw[48] != w_sum_raw[47]) begin
            w_sum_sat = w_sum_raw[48] ? tgpid_pkg::SUM_MIN : tgpid_pkg::SUM_MAX;
        end else begin
            w_sum_sat = w_sum_raw[47:0];
        end
    end

    // Time gates on wrapping elapsed time
    assign w_i_elapsed = r_a_now - r_itime;
    assign w_d_elapsed = r_a_now - r_dtime;
    assign w_i_gate    = w_i_elapsed >= {6'b0, tgpid_pkg::period_ms(i_cfg.int_period)};
    assign w_d_gate    = w_d_elapsed >= {6'b0, tgpid_pkg::period_ms(i_cfg.der_period)};
    assign w_hist_full = r_hist[1];

    // Second difference, exact in 35 bits
    assign w_d2 = {{3{r_a_meas[31]}}, r_a_meas}
                - {{2{r_prev[31]}}, r_prev, 1'b0}
                + {{3{r_pprev[31]}}, r_pprev};

    // Advance controller state as each item leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_isum  <= '0;
            r_itime <= '0;
            r_dtime <= '0;
            r_prev  <= '0;
            r_pprev <= '0;
            r_hist  <= '0;
        end else if (w_fire_ab) begin
            if (!w_compute) begin
                r_isum  <= '0;
                r_itime <= r_a_now;
                r_dtime <= r_a_now;
                r_prev  <= '0;
                r_pprev <= '0;
                r_hist  <= '0;
            end else begin
                if (w_i_gate) begin
                    r_isum  <= w_sum_sat;
                    r_itime <= r_a_now;
                end
                if (w_d_gate) begin
                    r_dtime <= r_a_now;
                    case (r_hist)
                        2'd0: begin
                            r_pprev <= r_a_meas;
                            r_hist  <= 2'd1;
                        end
                        2'd1: begin
                            r_prev <= r_a_meas;
                            r_hist <= 2'd2;
                        end
                        default: begin
                            r_pprev <= r_prev;
                            r_prev  <= r_a_meas;
                        end
                    endcase
                end
            end
        end
    end

    // Operand register; clear items drop out here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_ready_b) begin
            r_b_valid <= r_a_valid && w_compute;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire_ab) begin
            r_b_err   <= w_err;
            r_b_sum   <= w_sum_sat;
            r_b_d2    <= w_d2;
            r_b_iused <= w_i_gate;
            r_b_dused <= w_d_gate && w_hist_full;
        end
    end

    assign o_work = '{valid: r_b_valid,
                      err:   r_b_err,
                      sum:   r_b_sum,
                      d2:    r_b_d2,
                      iused: r_b_iused,
                      dused: r_b_dused};

endmodule

`default_nettype wire

// ===== rtl/core/tgpid_math.sv =====
`default_nettype none

module tgpid_math (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire tgpid_pkg::t_cfg  i_cfg,
    input  wire tgpid_pkg::t_work i_work,
    output logic                  o_ready,
    output logic                  o_tvalid,
    input  wire                   i_tready,
    output logic [31:0]           o_tdata,   // [31:0] drive
    output logic [1:0]            o_tuser    // [0] integral_used, [1] derivative_used
);

    // Product register
    logic               r_c_valid;
    logic signed [48:0] r_c_p;
    logic signed [63:0] r_c_ihi;
    logic signed [32:0] r_c_ilo;
    logic signed [50:0] r_c_d;
    logic               r_c_iused;
    logic               r_c_dused;

    // Output register
    logic               r_d_valid;
    logic [31:0]        r_d_drive;
    logic               r_d_iused;
    logic               r_d_dused;

    logic               w_ready_c;
    logic               w_ready_d;
    logic signed [64:0] w_prod_p;
    logic signed [63:0] w_prod_ihi;
    logic signed [48:0] w_prod_ilo;
    logic signed [66:0] w_prod_d;
    logic signed [65:0] w_total;
    logic               w_in_range;
    logic [31:0]        w_drive;

    assign w_ready_d = !r_d_valid || i_tready;
    assign w_ready_c = !r_c_valid || w_ready_d;
    assign o_ready   = w_ready_c;

    // Products; the integral product splits the 48-bit sum into high and low parts
    assign w_prod_p   = $signed(i_cfg.gain_p) * $signed(i_work.err);
    assign w_prod_ihi = $signed(i_cfg.gain_i) * $signed(i_work.sum[47:16]);
    assign w_prod_ilo = $signed(i_cfg.gain_i) * $signed({1'b0, i_work.sum[15:0]});
    assign w_prod_d   = $signed(i_cfg.gain_d) * $signed(i_work.d2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (w_ready_c) begin
            r_c_valid <= i_work.valid;
        end
    end

    // Drop 16 fraction bits (floor); zero the gated-off terms
    always_ff @(posedge i_clk) begin
        if (i_work.valid && w_ready_c) begin
            r_c_p     <= w_prod_p[64:16];
            r_c_ihi   <= i_work.iused ? w_prod_ihi : '0;
            r_c_ilo   <= i_work.iused ? w_prod_ilo[48:16] : '0;
            r_c_d     <= i_work.dused ? w_prod_d[66:16] : '0;
            r_c_iused <= i_work.iused;
            r_c_dused <= i_work.dused;
        end
    end

    // Sum the terms exactly, then saturate to 32 bits
    assign w_total = {{17{r_c_p[48]}}, r_c_p}
                   + {{2{r_c_ihi[63]}}, r_c_ihi}
                   + {{33{r_c_ilo[32]}}, r_c_ilo}
                   + {{15{r_c_d[50]}}, r_c_d};
    assign w_in_range = (&w_total[65:31]) || (~|w_total[65:31]);

    always_comb begin
        if (w_in_range) begin
            w_drive = w_total[31:0];
        end else begin
            w_drive = w_total[65] ? tgpid_pkg::DRIVE_MIN : tgpid_pkg::DRIVE_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (w_ready_d) begin
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_c_valid && w_ready_d) begin
            r_d_drive <= w_drive;
            r_d_iused <= r_c_iused;
            r_d_dused <= r_c_dused;
        end
    end

    assign o_tvalid = r_d_valid;
    assign o_tdata  = r_d_drive;
    assign o_tuser  = {r_d_dused, r_d_iused};

endmodule

`default_nettype wire

// ===== rtl/core/time_gated_pid_controller_top.sv =====
// Time-gated PID controller, signed Q15.16. Each compute item (tuser func = 0) carries a
// measured sample and a millisecond timestamp and yields one drive item; a clear item
// (func = 1) resets the integral sum and sample history, restarts both gate timers at its
// timestamp and yields nothing. The block takes one item every clock cycle unless an output
// stall has filled every stage, and returns a drive value through a four-stage pipeline:
// input register, state stage, multiply stage, sum-and-saturate output register. The rate
// is set by the state stage, which updates the integral sum, gate timestamps and history as
// each item leaves the input register, before the next item reads them. Output stalls fill
// the pipeline's empty stages before the input stops. The user must write registers through
// the APB port only while no items are in flight; the block itself does not enforce this.
`default_nettype none

module time_gated_pid_controller_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Register port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [4:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Sample items
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [63:0] s_axis_tdata,   // [31:0] measured, [63:32] now_ms
    input  wire  [0:0]  s_axis_tuser,   // [0] func
    // Drive items
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] drive
    output logic [1:0]  m_axis_tuser    // [0] integral_used, [1] derivative_used
);

    tgpid_pkg::t_cfg  w_cfg;
    tgpid_pkg::t_work w_work;
    logic             w_math_ready;

    tgpid_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    tgpid_state u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .i_tuser  (s_axis_tuser),
        .i_ready  (w_math_ready),
        .o_work   (w_work)
    );

    tgpid_math u_math (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_work   (w_work),
        .o_ready  (w_math_ready),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

// ===== rtl/core/tgpid_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module tgpid_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [31:0] m_axis_tdata,
    input wire [1:0]  m_axis_tuser
);

    logic w_idle_in;

    // No item taken while the output side drains
    assign w_idle_in = !(s_axis_tvalid && s_axis_tready) && m_axis_tready;

    // Hold a stalled drive item
    `TGPID_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // Input stalls only when the output holds a blocked drive item
    `TGPID_ASSERT_SAME(a_stall_only_when_full, i_clk, i_rst_n, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

    // Pipeline drains when no items enter and the output stays ready
    `TGPID_ASSERT_NEXT(a_drain, i_clk, i_rst_n, w_idle_in ##1 w_idle_in ##1 w_idle_in ##1 w_idle_in, !m_axis_tvalid)

    // Reset empties the output
    `TGPID_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !m_axis_tvalid)

endmodule

bind time_gated_pid_controller_top tgpid_checker u_checker (.*);

`default_nettype wire
